>>> hdl/chfr_pkg.sv
// ============================================================================
// chfr_pkg: shared types and constants for the cross forward recursion
// Field widths, fixed-point constants, lane control bundle and the 4x4
// transition coefficient pattern used by the lanes.
// ============================================================================
package chfr_pkg;

    // Field widths.
    localparam int RATE_W      = 16;
    localparam int HAP_W       = 17;
    localparam int WEIGHT_W    = 33;
    localparam int NUM_PATHS   = 4;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;

    // Fixed-point ones: Q1.16 haplotype and Q1.32 weight.
    localparam logic [HAP_W-1:0]    HAP_ONE = 17'h1_0000;
    localparam logic [WEIGHT_W-1:0] Q32_ONE = 33'h1_0000_0000;

    // Four path weights, one per lane.
    typedef logic [NUM_PATHS-1:0][WEIGHT_W-1:0] weight_vec_t;

    // Per-cycle controls that the sequencer hands to every lane.
    typedef struct packed {
        logic prod_en;
        logic acc_load;
        logic acc_add;
        logic mix_en;
    } lane_ctrl_t;

    // Which transition coefficient sits at a row and column.
    typedef enum logic [1:0] {
        COEF_A = 2'd0,
        COEF_B = 2'd1,
        COEF_C = 2'd2
    } coef_kind_t;

    // Paths within the same parent half mix with A on the diagonal and B
    // off it; paths across halves mix with C.
    function automatic coef_kind_t coef_kind(input logic [1:0] row, input logic [1:0] col);
        coef_kind_t kind;
        if (row[1] != col[1]) begin
            kind = COEF_C;
        end else if (row[0] == col[0]) begin
            kind = COEF_A;
        end else begin
            kind = COEF_B;
        end
        return kind;
    endfunction

    // Haplotype values above one clamp to one.
    function automatic logic [HAP_W-1:0] sat_hap(input logic [HAP_W-1:0] h);
        logic [HAP_W-1:0] v;
        v = (h > HAP_ONE) ? HAP_ONE : h;
        return v;
    endfunction

endpackage

>>> hdl/chfr_lane.sv
// ============================================================================
// chfr_lane: one path-weight lane
// Accumulates coefficient times old weight over four column steps (split
// into high and low weight halves), floors and clamps the mixed weight, and
// scales it by the lane's haplotype value.
// ============================================================================
module chfr_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  chfr_pkg::lane_ctrl_t                ctrl,
    input  logic [chfr_pkg::WEIGHT_W-1:0]       coef,
    input  logic [chfr_pkg::WEIGHT_W-1:0]       weight,
    input  logic [chfr_pkg::HAP_W-1:0]          hap,
    output logic [chfr_pkg::WEIGHT_W-1:0]       scaled
);
    import chfr_pkg::*;

    logic [49:0] p_hi_reg;
    logic [48:0] p_lo_reg;
    logic [51:0] acc_hi_reg;
    logic [50:0] acc_lo_reg;
    logic [52:0] mix_sum;
    logic [36:0] mix_floor;
    logic [WEIGHT_W-1:0] m_reg;
    logic [49:0] scale_prod;

    // Column products, high and low weight halves in parallel.
    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            p_hi_reg <= 50'(coef) * 50'(weight[32:16]);
            p_lo_reg <= 49'(coef) * 49'(weight[15:0]);
        end
    end

    // Accumulate the registered products one step behind.
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_load)
        begin
            acc_hi_reg <= 52'(p_hi_reg);
            acc_lo_reg <= 51'(p_lo_reg);
        end
        else if (ctrl.acc_add)
        begin
            acc_hi_reg <= acc_hi_reg + 52'(p_hi_reg);
            acc_lo_reg <= acc_lo_reg + 51'(p_lo_reg);
        end
    end

    // Exact floor of the mixed sum over 2^32, clamped to one.
    assign mix_sum   = 53'(acc_hi_reg) + 53'(acc_lo_reg[50:16]);
    assign mix_floor = mix_sum[52:16];

    always_ff @(posedge clk)
    begin
        if (ctrl.mix_en)
        begin
            m_reg <= (mix_floor > 37'(Q32_ONE)) ? Q32_ONE : mix_floor[32:0];
        end
    end

    // Scale by the haplotype value; the result never exceeds one.
    assign scale_prod = 50'(m_reg) * 50'(hap);
    assign scaled     = scale_prod[48:16];

    // The clamped mixed weight is never above one.
    a_mix_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mix_en |=> (m_reg <= Q32_ONE))
        else $error("lane mixed weight above one");

endmodule

>>> hdl/chfr_merge.sv
// ============================================================================
// chfr_merge: merging stage and result register
// Sums the four lane weights, clamps the total to one and holds it in the
// output register until the downstream side takes the beat.
// ============================================================================
module chfr_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  chfr_pkg::weight_vec_t               weights,
    output logic                                load_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [chfr_pkg::OUT_TDATA_W-1:0]    m_tdata   // [32:0] cross_value
);
    import chfr_pkg::*;

    logic [34:0] sum;
    logic [WEIGHT_W-1:0] value_reg;
    logic valid_reg;
    logic valid_next;

    // Adder tree over the four weights.
    assign sum = (35'(weights[0]) + 35'(weights[1])) + (35'(weights[2]) + 35'(weights[3]));

    // The register can take a new total when empty or being drained.
    assign load_ready = !valid_reg || m_tready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= (sum > 35'(Q32_ONE)) ? Q32_ONE : sum[32:0];
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-WEIGHT_W){1'b0}}, value_reg};

    // The emitted total is clamped to one.
    a_out_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32:0] <= Q32_ONE))
        else $error("cross value above one");

endmodule

>>> hdl/cross_haplotype_forward_recursion_top.sv
// ============================================================================
// cross_haplotype_forward_recursion_top: forward recursion over one cross
// Loci stream in on the s_ channel; the cross total leaves on the m_ channel.
//
// Usage: send the loci of a cross in order, one beat per locus. s_tuser marks
// the first locus, which loads the four path weights as a quarter of each
// haplotype value. s_tlast marks the last locus; one m_ beat carrying the
// Q1.32 sum of the four weights, clamped to one, follows it. Other loci
// yield no output. A first locus is taken in the idle state; every later
// locus runs the four column steps of the shared multiplier pair in each
// lane plus accumulate, mix and scale. A last locus then moves the total into
// the output register in a sum step. s_tready is high only between loci.
// Four lanes, one per path weight, run side by side.
// When the receiver stalls, the total waits in the output register and the
// next cross can already start; only a further last locus waits for it.
// Reset clears the weights to zero, empties the output and idles the block.
// ============================================================================
module cross_haplotype_forward_recursion_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] recomb_rate, [32:16] hap_p1a, [49:33] hap_p1b,
    // [66:50] hap_p2a, [83:67] hap_p2b
    input  logic [chfr_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tuser,  // [0] first_locus
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [chfr_pkg::OUT_TDATA_W-1:0]    m_tdata   // [32:0] cross_value
);
    import chfr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_MIX   = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_SUM   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [1:0] col_reg;
    logic [1:0] col_next;

    logic accept;
    logic [RATE_W-1:0] rate_in;
    logic [NUM_PATHS-1:0][HAP_W-1:0] hap_in;
    logic [HAP_W-1:0] s_in;
    logic [33:0] a_full;
    logic [32:0] b_full;

    logic [NUM_PATHS-1:0][HAP_W-1:0] hap_reg;
    logic last_reg;
    logic [WEIGHT_W-1:0] a_reg;
    logic [WEIGHT_W-1:0] b_reg;
    logic [WEIGHT_W-1:0] c_reg;
    weight_vec_t weights_reg;

    lane_ctrl_t lane_ctrl;
    weight_vec_t lane_coef;
    weight_vec_t lane_scaled;
    logic [WEIGHT_W-1:0] col_weight;
    logic merge_load;
    logic merge_ready;

    // Input beat unpacking with haplotype saturation.
    assign accept  = s_tvalid && s_tready;
    assign rate_in = s_tdata[RATE_W-1:0];

    always_comb
    begin
        for (int k = 0; k < NUM_PATHS; k++)
        begin
            hap_in[k] = sat_hap(s_tdata[RATE_W + HAP_W*k +: HAP_W]);
        end
    end

    // Transition coefficients, computed as the beat is taken.
    assign s_in   = HAP_ONE - {1'b0, rate_in};
    assign a_full = 34'(s_in) * 34'(s_in);
    assign b_full = 33'(s_in) * 33'(rate_in);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hap_reg  <= hap_in;
            last_reg <= s_tlast;
            a_reg    <= a_full[32:0];
            b_reg    <= b_full;
            c_reg    <= {2'b00, rate_in, 15'b0};
        end
    end

    // Sequencer.
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        case (state_reg)
            ST_IDLE:
            begin
                col_next = 2'd0;
                if (accept)
                begin
                    if (!s_tuser)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_MUL:
            begin
                col_next = col_reg + 2'd1;
                if (col_reg == 2'd3)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = last_reg ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                if (merge_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
        end
    end

    // Lane controls: products one step ahead of the accumulator.
    always_comb
    begin
        lane_ctrl.prod_en  = (state_reg == ST_MUL);
        lane_ctrl.acc_load = (state_reg == ST_MUL) && (col_reg == 2'd1);
        lane_ctrl.acc_add  = ((state_reg == ST_MUL) && col_reg[1]) || (state_reg == ST_DRAIN);
        lane_ctrl.mix_en   = (state_reg == ST_MIX);
    end

    // Column operands: the old weight and each row's coefficient.
    assign col_weight = weights_reg[col_reg];

    always_comb
    begin
        for (int j = 0; j < NUM_PATHS; j++)
        begin
            case (coef_kind(2'(j), col_reg))
                COEF_A:  lane_coef[j] = a_reg;
                COEF_B:  lane_coef[j] = b_reg;
                COEF_C:  lane_coef[j] = c_reg;
                default: lane_coef[j] = c_reg;
            endcase
        end
    end

    // One lane per path weight.
    for (genvar j = 0; j < NUM_PATHS; j++)
    begin : g_lane
        chfr_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl),
            .coef   (lane_coef[j]),
            .weight (col_weight),
            .hap    (hap_reg[j]),
            .scaled (lane_scaled[j])
        );
    end

    // Path weight state: loaded at a first locus, updated after scaling.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg <= '0;
        end
        else if (accept && s_tuser)
        begin
            for (int k = 0; k < NUM_PATHS; k++)
            begin
                weights_reg[k] <= {2'b00, hap_in[k], 14'b0};
            end
        end
        else if (state_reg == ST_SCALE)
        begin
            weights_reg <= lane_scaled;
        end
    end

    // Merging stage and output register.
    assign merge_load = (state_reg == ST_SUM) && merge_ready;

    chfr_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (merge_load),
        .weights    (weights_reg),
        .load_ready (merge_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // A later locus reaches the scaling step a fixed time after its beat.
    a_scale_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |-> ##7 (state_reg == ST_SCALE))
        else $error("scaling step out of schedule");

    // The total is only formed for a last locus.
    a_sum_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> last_reg)
        else $error("sum step without a last locus");

    // Path weights never exceed one.
    a_weights_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (weights_reg[0] <= Q32_ONE) && (weights_reg[1] <= Q32_ONE) &&
        (weights_reg[2] <= Q32_ONE) && (weights_reg[3] <= Q32_ONE))
        else $error("path weight above one");

endmodule

>>> tb/tb.sv
// ============================================================================
// tb: self-checking bench for cross_haplotype_forward_recursion_top
// Loci are streamed in as whole crosses with random content, plus stray and
// malformed loci. A bit-accurate model of the path weights predicts the total
// of each cross, and the monitor checks every output beat against it in order.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import chfr_pkg::*;

    // One locus as the bench sees it.
    typedef struct packed {
        logic                    first;
        logic                    last;
        logic [RATE_W-1:0]       rate;
        logic [3:0][HAP_W-1:0]   hap;
        logic                    drain;
    } locus_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    // Loci waiting to be sent, the locus on the bus, and the cross totals
    // still owed by the block.
    locus_t                  loci_q[$];
    locus_t                  on_bus;
    logic [WEIGHT_W-1:0]     cross_totals_q[$];

    // Model of the four path weights.
    logic [WEIGHT_W-1:0]     path_w[4];

    int                      mismatches = 0;
    int                      cycle_cnt = 0;
    logic                    calm;

    cross_haplotype_forward_recursion_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // No idling on either side during one long stretch of the run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end
    assign calm = (cycle_cnt >= 3000) && (cycle_cnt < 6000);

    initial
    begin
        for (int k = 0; k < 4; k++)
        begin
            path_w[k] = '0;
        end
    end

    // Apply one accepted locus to the path weights; queue the total if it
    // closes a cross.
    function automatic void advance_weights(input locus_t it);
        logic [HAP_W-1:0]    hap[4];
        logic [HAP_W-1:0]    keep;
        logic [33:0]         coef_a;
        logic [33:0]         coef_b;
        logic [33:0]         coef_c;
        logic [33:0]         coef;
        logic [WEIGHT_W-1:0] next_w[4];
        logic [67:0]         acc;
        logic [35:0]         mixed;
        logic [49:0]         scaled;
        logic [34:0]         total;
        for (int k = 0; k < 4; k++)
        begin
            hap[k] = (it.hap[k] > HAP_ONE) ? HAP_ONE : it.hap[k];
        end
        if (it.first)
        begin
            for (int k = 0; k < 4; k++)
            begin
                path_w[k] = WEIGHT_W'(hap[k]) << 14;
            end
        end
        else
        begin
            keep   = 17'h1_0000 - 17'(it.rate);
            coef_a = 34'(keep) * 34'(keep);
            coef_b = 34'(it.rate) * 34'(keep);
            coef_c = 34'(it.rate) << 15;
            for (int row = 0; row < 4; row++)
            begin
                acc = '0;
                for (int col = 0; col < 4; col++)
                begin
                    // Same parent half: A on the diagonal, B off it; across
                    // halves: C.
                    if ((row / 2) != (col / 2))
                        coef = coef_c;
                    else if (row == col)
                        coef = coef_a;
                    else
                        coef = coef_b;
                    acc = acc + 68'(coef) * 68'(path_w[col]);
                end
                mixed = 36'(acc >> 32);
                if (mixed > 36'(Q32_ONE))
                    mixed = 36'(Q32_ONE);
                scaled = 50'(mixed) * 50'(hap[row]);
                next_w[row] = WEIGHT_W'(scaled >> 16);
            end
            for (int k = 0; k < 4; k++)
            begin
                path_w[k] = next_w[k];
            end
        end
        if (it.last)
        begin
            total = '0;
            for (int k = 0; k < 4; k++)
            begin
                total = total + 35'(path_w[k]);
            end
            if (total > 35'(Q32_ONE))
                total = 35'(Q32_ONE);
            cross_totals_q.push_back(WEIGHT_W'(total));
        end
    endfunction

    function automatic locus_t make_locus(input logic first, input logic last,
                                          input logic [RATE_W-1:0] rate,
                                          input logic [HAP_W-1:0] h0,
                                          input logic [HAP_W-1:0] h1,
                                          input logic [HAP_W-1:0] h2,
                                          input logic [HAP_W-1:0] h3);
        locus_t it;
        it.first  = first;
        it.last   = last;
        it.rate   = rate;
        it.hap[0] = h0;
        it.hap[1] = h1;
        it.hap[2] = h2;
        it.hap[3] = h3;
        it.drain  = 1'b0;
        return it;
    endfunction

    // Mostly legal values, with the ends and the saturating range mixed in.
    function automatic logic [HAP_W-1:0] pick_hap();
        logic [HAP_W-1:0] h;
        case ($urandom_range(0, 9))
            0:       h = HAP_ONE;
            1:       h = '0;
            2:       h = HAP_W'($urandom_range(65537, 131071));
            3, 4:    h = HAP_W'($urandom_range(60000, 65536));
            default: h = HAP_W'($urandom_range(0, 65536));
        endcase
        return h;
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        logic [RATE_W-1:0] r;
        case ($urandom_range(0, 9))
            0:       r = '0;
            1:       r = RATE_W'($urandom_range(0, 65535));
            2:       r = RATE_W'($urandom_range(0, 2000));
            default: r = RATE_W'($urandom_range(0, 32768));
        endcase
        return r;
    endfunction

    // Sender: presents the next locus when the bus is free, idling at random.
    // A locus marked for draining waits until every owed total has arrived.
    always @(posedge clk)
    begin
        logic accepted;
        logic present;
        if (rst_n)
        begin
            accepted = s_tvalid && s_tready;
            if (accepted)
            begin
                advance_weights(on_bus);
            end
            if (!s_tvalid || accepted)
            begin
                present = (loci_q.size() > 0) && (calm || ($urandom_range(0, 99) >= 31));
                if (present && loci_q[0].drain && (cross_totals_q.size() != 0))
                begin
                    present = 1'b0;
                end
                if (present)
                begin
                    on_bus   <= loci_q[0];
                    s_tdata  <= {4'b0, loci_q[0].hap, loci_q[0].rate};
                    s_tuser  <= loci_q[0].first;
                    s_tlast  <= loci_q[0].last;
                    s_tvalid <= 1'b1;
                    void'(loci_q.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(input string what, input logic [WEIGHT_W-1:0] want,
                                 input logic [WEIGHT_W-1:0] got);
        mismatches = mismatches + 1;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: cross_value expected 0x%09h, got 0x%09h",
                     $realtime, what, want, got);
        end
    endtask

    // Receiver: stalls at random and checks each output beat in order.
    always @(posedge clk)
    begin
        logic [WEIGHT_W-1:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (cross_totals_q.size() == 0)
                begin
                    note_mismatch("unexpected beat", '0, m_tdata[WEIGHT_W-1:0]);
                end
                else
                begin
                    want = cross_totals_q.pop_front();
                    if (m_tdata[WEIGHT_W-1:0] !== want)
                    begin
                        note_mismatch("wrong total", want, m_tdata[WEIGHT_W-1:0]);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        locus_t it;
        int     n_items;
        int     len;
        // A later locus straight after reset mixes the cleared weights.
        loci_q.push_back(make_locus(1'b0, 1'b1, 16'd12345, HAP_ONE, HAP_ONE, HAP_ONE, HAP_ONE));
        // Single-locus crosses: full, saturated and empty haplotypes; the
        // rate at a first locus has no effect.
        loci_q.push_back(make_locus(1'b1, 1'b1, 16'hFFFF, HAP_ONE, HAP_ONE, HAP_ONE, HAP_ONE));
        loci_q.push_back(make_locus(1'b1, 1'b1, 16'h0000, 17'h1FFFF, 17'h1FFFF,
                                    17'h1FFFF, 17'h1FFFF));
        loci_q.push_back(make_locus(1'b1, 1'b1, 16'h8000, '0, '0, '0, '0));
        // A cross through the rate extremes with full haplotypes.
        loci_q.push_back(make_locus(1'b1, 1'b0, 16'h1234, HAP_ONE, HAP_ONE, HAP_ONE, HAP_ONE));
        loci_q.push_back(make_locus(1'b0, 1'b0, 16'h0000, HAP_ONE, HAP_ONE, HAP_ONE, HAP_ONE));
        loci_q.push_back(make_locus(1'b0, 1'b0, 16'hFFFF, HAP_ONE, HAP_ONE, HAP_ONE, HAP_ONE));
        loci_q.push_back(make_locus(1'b0, 1'b0, 16'h8000, HAP_ONE, HAP_ONE, HAP_ONE, HAP_ONE));
        loci_q.push_back(make_locus(1'b0, 1'b1, 16'h8000, HAP_ONE, HAP_ONE, HAP_ONE, HAP_ONE));
        // Uneven haplotypes, with saturation at a later locus.
        loci_q.push_back(make_locus(1'b1, 1'b0, 16'h0000, HAP_ONE, 17'd0, 17'd32768, 17'd1));
        loci_q.push_back(make_locus(1'b0, 1'b0, 16'd1000, 17'h1FFFF, 17'h10001,
                                    17'd65535, 17'd40000));
        loci_q.push_back(make_locus(1'b0, 1'b1, 16'hFFFF, 17'd0, 17'h1FFFF, HAP_ONE, 17'd1));
        // Loci after a closed cross, without a new first, keep mixing.
        loci_q.push_back(make_locus(1'b0, 1'b0, 16'd5000, HAP_ONE, HAP_ONE, HAP_ONE, HAP_ONE));
        loci_q.push_back(make_locus(1'b0, 1'b1, 16'd300, HAP_ONE, 17'd50000, HAP_ONE, HAP_ONE));
        // A first inside an open cross restarts it.
        loci_q.push_back(make_locus(1'b1, 1'b0, 16'd7, 17'd20000, 17'd30000, 17'd40000, HAP_ONE));
        loci_q.push_back(make_locus(1'b1, 1'b0, 16'd9, 17'd65000, 17'd61000, 17'd62000, 17'd63000));
        loci_q.push_back(make_locus(1'b0, 1'b1, 16'd4096, HAP_ONE, HAP_ONE, 17'd64000, 17'd100));

        // Random part: mostly whole crosses, some stray loci. The first
        // random locus waits until the directed totals have all arrived.
        n_items = 0;
        while (n_items < 1600)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    it = make_locus(i == 0, i == len - 1, pick_rate(), pick_hap(),
                                    pick_hap(), pick_hap(), pick_hap());
                    it.drain = (n_items == 0);
                    loci_q.push_back(it);
                    n_items++;
                end
            end
            else
            begin
                it = make_locus(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                pick_rate(), pick_hap(), pick_hap(), pick_hap(), pick_hap());
                it.drain = (n_items == 0);
                loci_q.push_back(it);
                n_items++;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every locus to be taken and every total to come back.
        while ((loci_q.size() != 0) || s_tvalid)
            @(posedge clk);
        while (cross_totals_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
